@@ design/bis_pkg.sv @@
// Shared widths, register indexes and the MAC control group of the bilinear scaler.
`timescale 1ns / 1ps
package bis_pkg;

   localparam int PIX_W       = 32;
   localparam int SIZE_W      = 9;
   localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
   localparam int FRAC_W      = 16;
   localparam int NUM_W       = SIZE_W + FRAC_W;
   localparam int STEP_W      = NUM_W;
   localparam int POS_W       = 36;
   localparam int IX_W        = POS_W - FRAC_W + 1;
   localparam int WFRAC_W     = 8;
   localparam int WGT_W       = WFRAC_W + 1;
   localparam int FULL_WEIGHT = 1 << WFRAC_W;
   localparam int HALF_STEP   = 1 << (FRAC_W - 1);
   localparam int LANE_W      = 16;
   localparam int LANES       = 4;
   localparam int CH_W        = 8;
   localparam int CH5_W       = 5;
   localparam int CSR_ADDR_W  = 5;
   localparam logic [15:0] ALPHA_1555 = 16'h8000;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH    = 3'd0,
      REG_SRC_HEIGHT   = 3'd1,
      REG_DST_WIDTH    = 3'd2,
      REG_DST_HEIGHT   = 3'd3,
      REG_PIXEL_FORMAT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic enable;
      logic first;
      logic wide;
   } mac_ctrl_type;

endpackage

@@ design/bis_divider.sv @@
// Restoring divider for the per-frame step, one quotient bit per cycle.
`timescale 1ns / 1ps
module bis_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bis_pkg::NUM_W-1:0]  numer,
   input  logic [bis_pkg::SIZE_W-1:0] denom,
   output logic                       done,
   output logic [bis_pkg::NUM_W-1:0]  quotient
);
   import bis_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         // remainder stays below the divisor, so the top trial bit drops
         rem_in  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/bis_mac.sv @@
// Four-lane weighted accumulator that blends one neighbor per cycle and formats the pixel.
`timescale 1ns / 1ps
module bis_mac (
   input  logic                       clock,
   input  bis_pkg::mac_ctrl_type      ctrl,
   input  logic [bis_pkg::PIX_W-1:0]  pixel,
   input  logic [bis_pkg::WGT_W-1:0]  weight,
   output logic [bis_pkg::PIX_W-1:0]  result
);
   import bis_pkg::*;

   logic [LANE_W-1:0] acc_ff [LANES];
   logic [LANE_W-1:0] sum [LANES];
   logic [CH_W-1:0]   chan [LANES];

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         if (ctrl.wide) begin
            chan[c] = pixel[CH_W*c +: CH_W];
         end else if (c < LANES - 1) begin
            chan[c] = CH_W'(pixel[CH5_W*c +: CH5_W]);
         end else begin
            chan[c] = '0;
         end
         // weights sum to 256, so a lane never exceeds 16 bits
         sum[c] = (ctrl.first ? LANE_W'(0) : acc_ff[c]) + LANE_W'(chan[c] * weight);
      end
      if (ctrl.wide) begin
         result = {sum[3][LANE_W-1 -: CH_W], sum[2][LANE_W-1 -: CH_W],
                   sum[1][LANE_W-1 -: CH_W], sum[0][LANE_W-1 -: CH_W]};
      end else begin
         result = {16'h0000, ALPHA_1555
                   | {1'b0, sum[2][WFRAC_W +: CH5_W], sum[1][WFRAC_W +: CH5_W],
                      sum[0][WFRAC_W +: CH5_W]}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         for (int c = 0; c < LANES; c++) begin
            acc_ff[c] <= sum[c];
         end
      end
   end

endmodule

@@ design/bilinear_image_scaler.sv @@
// Top level of the bilinear scaler: pixel store, position sequencer and register port.
// A load item is written into the pixel store at acceptance; busy stays low, so one load a cycle.
// A pixel request shows its rsp_valid strobe after clamp, row base multiply, then four reads of
// the single pixel store port, one per cycle, into the MAC; busy holds off the next request until then.
// The first request of a frame also waits for the step dividers, one quotient bit a cycle.
// Synchronous reset clears counters, positions, steps and registers; the pixel store is not cleared.
`timescale 1ns / 1ps
module bilinear_image_scaler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [bis_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                           rsp_valid,
   output logic [bis_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                           rsp_frame_done,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bis_pkg::PIX_W-1:0]      pwdata,
   output logic [bis_pkg::PIX_W-1:0]      prdata,
   output logic                           pready
);
   import bis_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = ADDR_W + 1;
   localparam int WLIM   = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
   localparam int HLIM   = (MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT;
   localparam int BASE_W = 2 * SIZE_W;
   localparam logic [2:0] LAST_PHASE = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_PREP  = 5'b00100,
      ST_BASE  = 5'b01000,
      ST_FETCH = 5'b10000
   } state_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_coord(input logic signed [IX_W-1:0] c,
                                                     input logic [SIZE_W-1:0] size);
      logic signed [IX_W-1:0] lim;
      logic [SIZE_W-1:0]      r;
      lim = $signed(IX_W'(size));
      if (c < 0) begin
         r = '0;
      end else if (c >= lim) begin
         r = size - 1'b1;
      end else begin
         r = c[SIZE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] start_pos(input logic [STEP_W-1:0] step);
      return $signed(POS_W'(step >> 1)) - $signed(POS_W'(HALF_STEP));
   endfunction

   // configuration
   logic [SIZE_W-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic              pixel_format_ff;
   logic              cfg_we;
   reg_index_type     cfg_idx;

   // sequencer and position state
   state_type                state_ff, state_in;
   logic [2:0]               phase_ff, phase_in;
   logic [ADDR_W-1:0]        load_idx_ff, load_idx_in;
   logic [SIZE_W-1:0]        col_ff, col_in, row_ff, row_in;
   logic signed [POS_W-1:0]  col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [STEP_W-1:0]        col_step_ff, col_step_in, row_step_ff, row_step_in;

   // per-pixel working registers
   logic [SIZE_W-1:0]  cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic [WFRAC_W-1:0] u_ff, v_ff, w3_ff;
   logic [BASE_W-1:0]  base0_ff, base1_ff;
   logic [PIX_W-1:0]   rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic               rsp_done_ff, rsp_done_in;

   logic [PIX_W-1:0]   store_mem [DEPTH];

   logic [SIZE_W-1:0]       sw, sh, dw, dh;
   logic [BASE_W-1:0]       area;
   logic [TOT_W-1:0]        total;
   logic                    accept, load_we, div_start, col_div_done, row_div_done;
   logic [ADDR_W-1:0]       wr_addr;
   logic [TOT_W-1:0]        load_next;
   logic [NUM_W-1:0]        col_quo, row_quo;
   logic [STEP_W-1:0]       new_col_step, new_row_step;
   logic signed [IX_W-1:0]  ix0, ix1, iy0, iy1;
   logic                    rd_en;
   logic [BASE_W-1:0]       rd_base;
   logic [SIZE_W-1:0]       rd_cx;
   logic [BASE_W:0]         rd_sum;
   logic [ADDR_W-1:0]       rd_addr;
   logic [WGT_W-1:0]        w0, w1, w2, w3, mac_weight;
   logic [WGT_W:0]          w0_wide;
   logic [WFRAC_W*2-1:0]    uv;
   logic [SIZE_W-1:0]       col_next, row_next;
   mac_ctrl_type            mac_ctrl;
   logic [PIX_W-1:0]        mac_result;

   assign sw    = eff_size(src_width_ff,  SIZE_W'(WLIM));
   assign sh    = eff_size(src_height_ff, SIZE_W'(HLIM));
   assign dw    = eff_size(dst_width_ff,  SIZE_W'(WLIM));
   assign dh    = eff_size(dst_height_ff, SIZE_W'(HLIM));
   assign area  = BASE_W'(sw) * BASE_W'(sh);
   assign total = TOT_W'(area);

   // register port
   assign pready  = 1'b1;
   assign cfg_we  = psel & penable & pwrite;
   assign cfg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= SIZE_W'(1);
         src_height_ff   <= SIZE_W'(1);
         dst_width_ff    <= SIZE_W'(1);
         dst_height_ff   <= SIZE_W'(1);
         pixel_format_ff <= 1'b1;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_SRC_WIDTH:    src_width_ff    <= pwdata[SIZE_W-1:0];
            REG_SRC_HEIGHT:   src_height_ff   <= pwdata[SIZE_W-1:0];
            REG_DST_WIDTH:    dst_width_ff    <= pwdata[SIZE_W-1:0];
            REG_DST_HEIGHT:   dst_height_ff   <= pwdata[SIZE_W-1:0];
            REG_PIXEL_FORMAT: pixel_format_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_SRC_WIDTH:    prdata = PIX_W'(src_width_ff);
         REG_SRC_HEIGHT:   prdata = PIX_W'(src_height_ff);
         REG_DST_WIDTH:    prdata = PIX_W'(dst_width_ff);
         REG_DST_HEIGHT:   prdata = PIX_W'(dst_height_ff);
         REG_PIXEL_FORMAT: prdata = PIX_W'(pixel_format_ff);
         default:          prdata = '0;
      endcase
   end

   // handshake and loads
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign load_we   = accept & ~req_op;
   assign div_start = accept & req_op & (col_ff == '0) & (row_ff == '0);

   always_comb begin
      wr_addr     = (TOT_W'(load_idx_ff) >= total) ? '0 : load_idx_ff;
      load_next   = TOT_W'(wr_addr) + 1'b1;
      load_idx_in = load_idx_ff;
      if (load_we) begin
         load_idx_in = (load_next >= total) ? '0 : load_next[ADDR_W-1:0];
      end
   end

   bis_divider u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    ({sw, FRAC_W'(0)}),
      .denom    (dw),
      .done     (col_div_done),
      .quotient (col_quo)
   );

   bis_divider u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    ({sh, FRAC_W'(0)}),
      .denom    (dh),
      .done     (row_div_done),
      .quotient (row_quo)
   );

   assign new_col_step = col_quo + 1'b1;
   assign new_row_step = row_quo + 1'b1;

   // integer parts are floor, so an arithmetic slice of the position does it
   assign ix0 = $signed({col_pos_ff[POS_W-1], col_pos_ff[POS_W-1:FRAC_W]});
   assign iy0 = $signed({row_pos_ff[POS_W-1], row_pos_ff[POS_W-1:FRAC_W]});
   assign ix1 = IX_W'(ix0 + 1);
   assign iy1 = IX_W'(iy0 + 1);
   assign uv  = u_ff * v_ff;

   // neighbor order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
   always_comb begin
      rd_en = (state_ff == ST_FETCH) && (phase_ff < LAST_PHASE);
      case (phase_ff)
         3'd0:    begin rd_base = base0_ff; rd_cx = cx0_ff; end
         3'd1:    begin rd_base = base0_ff; rd_cx = cx1_ff; end
         3'd2:    begin rd_base = base1_ff; rd_cx = cx0_ff; end
         default: begin rd_base = base1_ff; rd_cx = cx1_ff; end
      endcase
      rd_sum  = {1'b0, rd_base} + (BASE_W + 1)'(rd_cx);
      rd_addr = ADDR_W'(rd_sum);
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         store_mem[wr_addr] <= req_pixel_in;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      w3      = WGT_W'(w3_ff);
      w2      = WGT_W'(u_ff) - w3;
      w1      = WGT_W'(v_ff) - w3;
      w0_wide = (WGT_W + 1)'(FULL_WEIGHT) - (WGT_W + 1)'(u_ff) - (WGT_W + 1)'(v_ff)
                + (WGT_W + 1)'(w3_ff);
      w0      = w0_wide[WGT_W-1:0];
      case (phase_ff)
         3'd1:    mac_weight = w0;
         3'd2:    mac_weight = w2;
         3'd3:    mac_weight = w1;
         default: mac_weight = w3;
      endcase
      mac_ctrl.enable = (state_ff == ST_FETCH) && (phase_ff != 3'd0);
      mac_ctrl.first  = (phase_ff == 3'd1);
      mac_ctrl.wide   = pixel_format_ff;
   end

   bis_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .pixel  (rd_data_ff),
      .weight (mac_weight),
      .result (mac_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      col_step_in  = col_step_ff;
      row_step_in  = row_step_ff;
      rsp_valid_in = 1'b0;
      rsp_done_in  = 1'b0;
      col_next     = col_ff + 1'b1;
      row_next     = row_ff + 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op) begin
               if (div_start) begin
                  state_in = ST_DIV;
               end else begin
                  if (col_ff == '0) begin
                     col_pos_in = start_pos(col_step_ff);
                  end
                  state_in = ST_PREP;
               end
            end
         end
         ST_DIV: begin
            if (col_div_done && row_div_done) begin
               col_step_in = new_col_step;
               row_step_in = new_row_step;
               col_pos_in  = start_pos(new_col_step);
               row_pos_in  = start_pos(new_row_step);
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            phase_in = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == LAST_PHASE) begin
               rsp_valid_in = 1'b1;
               col_pos_in   = col_pos_ff + $signed(POS_W'(col_step_ff));
               col_in       = col_next;
               if (col_next >= dw) begin
                  col_in     = '0;
                  row_pos_in = row_pos_ff + $signed(POS_W'(row_step_ff));
                  row_in     = row_next;
                  if (row_next >= dh) begin
                     row_in      = '0;
                     rsp_done_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         load_idx_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_step_ff  <= '0;
         row_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         load_idx_ff  <= load_idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_step_ff  <= col_step_in;
         row_step_ff  <= row_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         cx0_ff <= clamp_coord(ix0, sw);
         cx1_ff <= clamp_coord(ix1, sw);
         cy0_ff <= clamp_coord(iy0, sh);
         cy1_ff <= clamp_coord(iy1, sh);
         u_ff   <= col_pos_ff[FRAC_W-1 -: WFRAC_W];
         v_ff   <= row_pos_ff[FRAC_W-1 -: WFRAC_W];
      end
      if (state_ff == ST_BASE) begin
         base0_ff <= BASE_W'(cy0_ff) * BASE_W'(sw);
         base1_ff <= BASE_W'(cy1_ff) * BASE_W'(sw);
         w3_ff    <= uv[2*WFRAC_W-1 -: WFRAC_W];
      end
      if (rsp_valid_in) begin
         rsp_pixel_ff <= mac_result;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

@@ design/bis_checker.sv @@
// Port-level checks of the bilinear scaler's command handshake, bound to the top level.
`timescale 1ns / 1ps
module bis_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_valid
);

   // a request always spans several cycles, so strobes never touch
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op) |=> busy)
      else $error("pixel request item did not raise busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_op) |=> !busy)
      else $error("load item raised busy");

   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a request");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_valid (rsp_valid)
);

@@ dv/tb_bilinear_image_scaler.sv @@
// Self-checking testbench for the bilinear scaler: directed table, then random frames.
`timescale 1ns / 1ps
module tb_bilinear_image_scaler;
   import bis_pkg::*;

   localparam int MAX_W        = 256;
   localparam int MAX_H        = 256;
   localparam int STORE_DEPTH  = MAX_W * MAX_H;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_AREA     = 1024;
   localparam int MAX_REQS     = 300;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
   localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             done;
   } scaled_pixel_t;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_LOAD,
      ROW_REQ
   } row_kind_t;

   typedef struct packed {
      row_kind_t        kind;
      logic [2:0]       index;
      logic [PIX_W-1:0] data;
      logic             typed;
      logic [PIX_W-1:0] exp_pixel;
      logic             exp_done;
   } dir_row_t;

   // A 1x1 source gives all four neighbors the same pixel, so the result is the pixel itself.
   localparam int NUM_ROWS = 36;
   localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_LOAD, REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'hA5C3_5A3C, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'hA5C3_5A3C, 1'b1},
      '{ROW_CFG,  REG_PIXEL_FORMAT, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'h0000_FFFF, 1'b1},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b1, 32'h0000_8000, 1'b1},
      '{ROW_CFG,  REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_DST_WIDTH,    32'hABCD_E003, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'h0000_2AD5, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'h0000_AAD5, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'h0000_AAD5, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b1, 32'h0000_AAD5, 1'b1},
      '{ROW_CFG,  REG_PIXEL_FORMAT, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_UNMAPPED_LO,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_UNMAPPED_HI,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_SRC_WIDTH,    32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_SRC_HEIGHT,   32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_DST_HEIGHT,   32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'hFF00_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'h00FF_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'h0000_FF00, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_LOAD, REG_SRC_WIDTH,    32'h0000_00FF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CFG,  REG_PIXEL_FORMAT, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  REG_SRC_WIDTH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = 1'b0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_done;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [PIX_W-1:0]      pwdata = '0;
   logic [PIX_W-1:0]      prdata;
   logic                  pready;

   bilinear_image_scaler #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_done (rsp_frame_done),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Predictor state: register copies, source image and scan position.
   logic [SIZE_W-1:0] cfg_src_w = 9'd1;
   logic [SIZE_W-1:0] cfg_src_h = 9'd1;
   logic [SIZE_W-1:0] cfg_dst_w = 9'd1;
   logic [SIZE_W-1:0] cfg_dst_h = 9'd1;
   logic              cfg_wide  = 1'b1;
   logic [PIX_W-1:0]  src_image   [0:STORE_DEPTH-1];
   bit                src_written [0:STORE_DEPTH-1];
   int unsigned       load_ptr = 0;
   int unsigned       dst_col = 0;
   int unsigned       dst_row = 0;
   longint            x_acc = 0;
   longint            y_acc = 0;
   longint            x_step = 0;
   longint            y_step = 0;

   scaled_pixel_t pending_pixels [$];
   int unsigned   mismatches = 0;
   int unsigned   loads_sent = 0;
   int unsigned   requests_sent = 0;
   int unsigned   settings_count = 0;
   int unsigned   burst_left = 0;
   int unsigned   cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned active_size(input logic [SIZE_W-1:0] v,
                                               input int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function automatic int unsigned clamp_coord(input longint c, input int unsigned size);
      if (c < 0) return 0;
      if (c >= longint'(size)) return size - 1;
      return c[31:0];
   endfunction

   function automatic logic [PIX_W-1:0] neighbor_at(input longint x, input longint y,
                                                    input int unsigned sw,
                                                    input int unsigned sh);
      return src_image[clamp_coord(y, sh) * sw + clamp_coord(x, sw)];
   endfunction

   function automatic logic [PIX_W-1:0] mix_neighbors(input logic [PIX_W-1:0] p0, p1, p2, p3,
                                                      input logic [7:0] u, v,
                                                      input logic wide);
      logic [31:0] w0, w1, w2, w3, hi, lo, s, mix;
      logic [31:0] lane_mask [3];
      lane_mask = '{32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F};
      w3 = ({24'b0, u} * {24'b0, v}) >> 8;
      w2 = {24'b0, u} - w3;
      w1 = {24'b0, v} - w3;
      w0 = 32'd256 - w1 - w2 - w3;
      if (wide) begin
         // two byte lanes per word, weights sum to 256 so lanes never carry into each other
         hi = ((p0 & 32'hFF00_FF00) >> 8) * w0 + ((p1 & 32'hFF00_FF00) >> 8) * w2
            + ((p2 & 32'hFF00_FF00) >> 8) * w1 + ((p3 & 32'hFF00_FF00) >> 8) * w3;
         lo = (p0 & 32'h00FF_00FF) * w0 + (p1 & 32'h00FF_00FF) * w2
            + (p2 & 32'h00FF_00FF) * w1 + (p3 & 32'h00FF_00FF) * w3;
         mix = (hi & 32'hFF00_FF00) | ((lo & 32'hFF00_FF00) >> 8);
      end else begin
         mix = {16'b0, ALPHA_1555};
         for (int k = 0; k < 3; k++) begin
            s = (w0 * (p0 & lane_mask[k]) + w2 * (p1 & lane_mask[k])
               + w1 * (p2 & lane_mask[k]) + w3 * (p3 & lane_mask[k])) >> 8;
            mix |= s & lane_mask[k];
         end
      end
      return mix;
   endfunction

   function automatic bit all_written(input int unsigned total);
      for (int i = 0; i < total; i++) begin
         if (!src_written[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return 9'd0;
      if (r < 10) return 9'd256;
      if (r < 15) return $urandom_range(257, 511);
      if (r < 22) return $urandom_range(9, 255);
      return $urandom_range(1, 8);
   endfunction

   // Sometimes dirty the unused upper data bits of a register write.
   function automatic logic [PIX_W-1:0] noisy(input logic [PIX_W-1:0] v);
      if ($urandom_range(0, 3) == 0) return ($urandom() & 32'hFFFF_FE00) | v;
      return v;
   endfunction

   task automatic apply_register(input logic [2:0] idx, input logic [PIX_W-1:0] value);
      case (idx)
         REG_SRC_WIDTH:    cfg_src_w = value[SIZE_W-1:0];
         REG_SRC_HEIGHT:   cfg_src_h = value[SIZE_W-1:0];
         REG_DST_WIDTH:    cfg_dst_w = value[SIZE_W-1:0];
         REG_DST_HEIGHT:   cfg_dst_h = value[SIZE_W-1:0];
         REG_PIXEL_FORMAT: cfg_wide  = value[0];
         default: ;
      endcase
   endtask

   // Advances the predictor by one accepted item; a request yields one scaled pixel.
   task automatic scale_item(input logic op, input logic [PIX_W-1:0] pix,
                             output bit produced, output scaled_pixel_t res);
      int unsigned sw, sh, dw, dh, total;
      longint      ix, iy;
      logic [7:0]  u, v;
      sw = active_size(cfg_src_w, MAX_W);
      sh = active_size(cfg_src_h, MAX_H);
      dw = active_size(cfg_dst_w, MAX_W);
      dh = active_size(cfg_dst_h, MAX_H);
      total = sw * sh;
      produced = 1'b0;
      res = '0;
      if (op == OP_LOAD) begin
         if (load_ptr >= total) load_ptr = 0;
         src_image[load_ptr] = pix;
         src_written[load_ptr] = 1'b1;
         load_ptr++;
         if (load_ptr >= total) load_ptr = 0;
      end else begin
         if (dst_col == 0) begin
            if (dst_row == 0) begin
               x_step = ((longint'(sw) << FRAC_W) / dw) + 1;
               y_step = ((longint'(sh) << FRAC_W) / dh) + 1;
               y_acc = (y_step >>> 1) - HALF_STEP;
            end
            x_acc = (x_step >>> 1) - HALF_STEP;
         end
         // arithmetic shift floors negative start positions
         ix = x_acc >>> FRAC_W;
         iy = y_acc >>> FRAC_W;
         u = x_acc[15:8];
         v = y_acc[15:8];
         res.pixel = mix_neighbors(neighbor_at(ix, iy, sw, sh), neighbor_at(ix + 1, iy, sw, sh),
                                   neighbor_at(ix, iy + 1, sw, sh),
                                   neighbor_at(ix + 1, iy + 1, sw, sh), u, v, cfg_wide);
         x_acc += x_step;
         dst_col++;
         if (dst_col >= dw) begin
            dst_col = 0;
            y_acc += y_step;
            dst_row++;
            if (dst_row >= dh) begin
               dst_row = 0;
               res.done = 1'b1;
            end
         end
         produced = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
                                  input logic [PIX_W-1:0] got);
      $display("MISMATCH %s: want %h got %h at cycle %0d", what, want, got, cycle_count);
      mismatches++;
   endtask

   task automatic send_item(input logic op, input logic [PIX_W-1:0] pix, input logic typed,
                            input scaled_pixel_t typed_res);
      bit            produced;
      scaled_pixel_t res;
      start <= 1'b1;
      req_op <= op;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy !== 1'b0);
      scale_item(op, pix, produced, res);
      if (produced) pending_pixels.push_back(typed ? typed_res : res);
      if (op == OP_LOAD) loads_sent++;
      else requests_sent++;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [PIX_W-1:0] value);
      logic [PIX_W-1:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      apply_register(idx, value);
      if (idx <= REG_PIXEL_FORMAT) begin
         want = (idx == REG_PIXEL_FORMAT) ? {31'b0, value[0]} : {23'b0, value[SIZE_W-1:0]};
         penable <= 1'b0;
         pwrite <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (pready !== 1'b1);
         if (prdata !== want) report_mismatch("register read-back", want, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_count++;
   endtask

   // Idle the block: all pixels back, then room for a request still in its pipeline.
   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_pixels
      scaled_pixel_t want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("pixel with none pending", '0, rsp_pixel_out);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_mismatch("pixel_out", want.pixel, rsp_pixel_out);
            if (rsp_frame_done !== want.done)
               report_mismatch("frame_done", {31'b0, want.done}, {31'b0, rsp_frame_done});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels pending", cycle_count,
                  pending_pixels.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned       sw, sh, dw, dh, total, n_load, n_req, phase, base;
      logic [SIZE_W-1:0] nsw, nsh, ndw, ndh;
      logic              nfmt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         case (DIRECTED_ROWS[i].kind)
            ROW_CFG: begin
               settle();
               write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
            end
            default: begin
               send_item((DIRECTED_ROWS[i].kind == ROW_REQ) ? OP_REQUEST : OP_LOAD,
                         DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
                         {DIRECTED_ROWS[i].exp_pixel, DIRECTED_ROWS[i].exp_done});
            end
         endcase
      end

      base = loads_sent + requests_sent;
      for (phase = 0; loads_sent + requests_sent - base < RANDOM_ITEMS; phase++) begin
         settle();
         if (phase == 0) begin
            // widest source, tallest destination, source width written above the maximum
            nsw = 9'h1FF;
            nsh = 9'd1;
            ndw = 9'd1;
            ndh = 9'h100;
            nfmt = 1'b1;
         end else begin
            nsw = cfg_src_w;
            nsh = cfg_src_h;
            ndw = cfg_dst_w;
            ndh = cfg_dst_h;
            nfmt = cfg_wide;
            if ($urandom_range(0, 4) < 3) nsw = pick_size();
            if ($urandom_range(0, 4) < 3) nsh = pick_size();
            if ($urandom_range(0, 4) < 3) ndw = pick_size();
            if ($urandom_range(0, 4) < 3) ndh = pick_size();
            if ($urandom_range(0, 1) == 1) nfmt = $urandom_range(0, 1);
            if (active_size(nsw, MAX_W) * active_size(nsh, MAX_H) > MAX_AREA)
               nsh = $urandom_range(1, 4);
         end
         if (phase == 0 || nsw != cfg_src_w || $urandom_range(0, 3) == 0)
            write_register(REG_SRC_WIDTH, noisy(nsw));
         if (phase == 0 || nsh != cfg_src_h || $urandom_range(0, 3) == 0)
            write_register(REG_SRC_HEIGHT, noisy(nsh));
         if (phase == 0 || ndw != cfg_dst_w || $urandom_range(0, 3) == 0)
            write_register(REG_DST_WIDTH, noisy(ndw));
         if (phase == 0 || ndh != cfg_dst_h || $urandom_range(0, 3) == 0)
            write_register(REG_DST_HEIGHT, noisy(ndh));
         if (phase == 0 || nfmt != cfg_wide || $urandom_range(0, 3) == 0)
            write_register(REG_PIXEL_FORMAT, noisy(nfmt));

         sw = active_size(cfg_src_w, MAX_W);
         sh = active_size(cfg_src_h, MAX_H);
         dw = active_size(cfg_dst_w, MAX_W);
         dh = active_size(cfg_dst_h, MAX_H);
         total = sw * sh;

         // a partial reload is only safe once every pixel of the image has been written
         n_load = (all_written(total) && $urandom_range(0, 3) == 0) ? $urandom_range(0, total)
                                                                     : total;
         repeat (n_load) send_item(OP_LOAD, $urandom(), 1'b0, '0);

         // about one frame, sometimes cut short or running into the next one
         n_req = dw * dh;
         if (n_req > MAX_REQS) n_req = MAX_REQS;
         n_req = n_req + $urandom_range(0, 4);
         n_req = (n_req > 2) ? n_req - 2 : 1;
         repeat (n_req) begin
            if ($urandom_range(0, 9) == 0) send_item(OP_LOAD, $urandom(), 1'b0, '0);
            send_item(OP_REQUEST, $urandom(), 1'b0, '0);
         end
      end

      settle();
      $display("Sent %0d source loads and %0d pixel requests around %0d register writes,",
               loads_sent, requests_sent, settings_count);
      $display("with clamped sizes, both pixel formats and frames cut short by resizing.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
